@@ rtl/acp_pkg.sv @@
// Shared types and constants of the ASTERIX alert data block parser.
`default_nettype none
package acp_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CATEGORY_RESET = 8'd245;
    localparam logic [7:0] SPARE_MASK     = 8'h3E;

    // Parser phases
    typedef enum logic [2:0] {
        PH_CAT     = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_FSPEC   = 3'd3,
        PH_ALERT   = 3'd4,
        PH_TRACK   = 3'd5,
        PH_DONE    = 3'd6,
        PH_DISCARD = 3'd7
    } t_phase;

    // Result kinds
    localparam logic [1:0] KIND_ALERT = 2'd0;
    localparam logic [1:0] KIND_OK    = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_CATEGORY = 3'd1;
    localparam logic [2:0] ERR_LEN_LONG = 3'd2;
    localparam logic [2:0] ERR_SPARE    = 3'd3;
    localparam logic [2:0] ERR_FX       = 3'd4;
    localparam logic [2:0] ERR_OVERRUN  = 3'd5;
    localparam logic [2:0] ERR_OVERSIZE = 3'd6;

    // One queue entry: the results caused by one input byte, record first
    typedef struct packed {
        logic        rec_valid;
        logic [1:0]  alert_type;
        logic        track_present;
        logic [31:0] track_number;
        logic        st_valid;
        logic [2:0]  st_code;      // ERR_NONE means packet ok
    } t_entry;

endpackage
`default_nettype wire

@@ rtl/acp_if.sv @@
// Channel interfaces: input byte stream and result stream.
`default_nettype none
interface acp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface acp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [1:0]  alert_type;
    logic        track_present;
    logic [31:0] track_number;
    logic [2:0]  error_code;
    logic        run_last;

    modport source (output valid, output out_kind, output alert_type, output track_present,
                    output track_number, output error_code, output run_last, input ready);
    modport sink   (input valid, input out_kind, input alert_type, input track_present,
                    input track_number, input error_code, input run_last, output ready);
endinterface
`default_nettype wire

@@ rtl/acp_front.sv @@
// Front end: byte parser that classifies each byte and queues its results.
`default_nettype none
module acp_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [7:0]     i_cfg_wdata,
    acp_in_if.sink              i_in,
    input  wire logic           i_q_full,
    output logic                o_q_wr,
    output acp_pkg::t_entry     o_q_entry
);
    import acp_pkg::*;

    logic [7:0]  r_category;
    t_phase      r_phase,  n_phase;
    logic [16:0] r_pos,    n_pos;
    logic [15:0] r_len,    n_len;
    logic        r_trk,    n_trk;
    logic [2:0]  r_cnt,    n_cnt;
    logic [31:0] r_shift,  n_shift;
    logic [1:0]  r_alert,  n_alert;

    logic        accept;
    logic [7:0]  b;
    logic [16:0] pos_inc;
    logic        raise;
    logic [2:0]  code;
    logic        in_rec;
    logic        complete;
    logic        rec;
    logic        st_valid;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;
    assign pos_inc    = r_pos[16] ? r_pos : r_pos + 17'd1;  // saturates at 65536

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_trk    = r_trk;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_alert  = r_alert;
        n_pos    = pos_inc;
        raise    = 1'b0;
        code     = ERR_NONE;
        in_rec   = 1'b0;
        complete = 1'b0;
        rec      = 1'b0;

        if (r_phase != PH_DISCARD && pos_inc[16]) begin
            raise = 1'b1;
            code  = ERR_OVERSIZE;
        end else begin
            unique case (r_phase)
                PH_CAT: begin
                    if (b != r_category) begin
                        raise = 1'b1;
                        code  = ERR_CATEGORY;
                    end else begin
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_len   = {b, 8'h00};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len = {r_len[15:8], b};
                    if (n_len < 16'd3) begin
                        raise = 1'b1;
                        code  = ERR_OVERRUN;
                    end else if (n_len == 16'd3) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_FSPEC;
                    end
                end
                PH_FSPEC: begin
                    in_rec  = 1'b1;
                    n_trk   = b[6];
                    n_alert = 2'd0;
                    n_shift = 32'd0;
                    n_cnt   = 3'd0;
                    if ((b & SPARE_MASK) != 8'h00) begin
                        raise = 1'b1;
                        code  = ERR_SPARE;
                    end else if (b[0]) begin
                        raise = 1'b1;
                        code  = ERR_FX;
                    end else if (b[7]) begin
                        n_phase = PH_ALERT;
                    end else if (b[6]) begin
                        n_phase = PH_TRACK;
                        n_cnt   = 3'd4;
                    end else begin
                        complete = 1'b1;
                    end
                end
                PH_ALERT: begin
                    in_rec  = 1'b1;
                    n_alert = (b[7:2] == 6'd0) ? b[1:0] : 2'd0;  // unknown code -> none
                    if (r_trk) begin
                        n_phase = PH_TRACK;
                        n_cnt   = 3'd4;
                    end else begin
                        complete = 1'b1;
                    end
                end
                PH_TRACK: begin
                    in_rec   = 1'b1;
                    n_shift  = {r_shift[23:0], b};
                    n_cnt    = r_cnt - 3'd1;
                    complete = (n_cnt == 3'd0);
                end
                default: begin
                end
            endcase

            if (in_rec && !raise) begin
                if (complete) begin
                    rec     = 1'b1;
                    n_phase = (pos_inc >= {1'b0, r_len}) ? PH_DONE : PH_FSPEC;
                end else if (pos_inc >= {1'b0, r_len}) begin
                    raise = 1'b1;
                    code  = ERR_OVERRUN;
                end
            end
        end

        if (raise) begin
            n_phase = PH_DISCARD;
        end

        // status: error on this byte, or end of buffer without an earlier error
        st_valid = raise || (i_in.last_byte && n_phase != PH_DISCARD);
        if (!raise) begin
            code = (n_phase == PH_DONE) ? ERR_NONE : ERR_LEN_LONG;
        end

        o_q_entry.rec_valid     = rec;
        o_q_entry.alert_type    = n_alert;
        o_q_entry.track_present = n_trk;
        o_q_entry.track_number  = n_trk ? n_shift : 32'd0;
        o_q_entry.st_valid      = st_valid;
        o_q_entry.st_code       = code;

        if (i_in.last_byte) begin
            n_phase = PH_CAT;
            n_pos   = 17'd0;
        end
    end

    assign o_q_wr = accept && (rec || st_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_category <= CATEGORY_RESET;
        end else if (i_cfg_we) begin
            r_category <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CAT;
            r_pos   <= 17'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_len   <= n_len;
            r_trk   <= n_trk;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_alert <= n_alert;
        end
    end

    // every buffer end returns the parser to the category byte
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.last_byte |=> r_phase == PH_CAT && r_pos == 17'd0)
        else $error("parser not reset after last byte");

    // a record never leaves a byte that raises an error
    a_err_no_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_wr && o_q_entry.rec_valid && o_q_entry.st_valid |-> !raise)
        else $error("record queued with an error status");

endmodule
`default_nettype wire

@@ rtl/acp_queue.sv @@
// Small FIFO of per-byte result entries between front and back.
`default_nettype none
module acp_queue #(
    parameter int DEPTH = acp_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire acp_pkg::t_entry i_wr_entry,
    input  wire logic           i_pop,
    output acp_pkg::t_entry     o_head,
    output logic                o_empty,
    output logic                o_full
);
    import acp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               do_wr;
    logic               do_rd;

    assign o_empty = (r_count == CNT_W'(0));
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : r_wr_ptr + PTR_W'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : r_rd_ptr + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    // front must never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("write to full result queue");

endmodule
`default_nettype wire

@@ rtl/acp_back.sv @@
// Back end: splits queue entries into result transactions via an output register.
`default_nettype none
module acp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire acp_pkg::t_entry i_head,
    input  wire logic           i_empty,
    output logic                o_pop,
    acp_out_if.source           o_out
);
    import acp_pkg::*;

    logic        r_out_valid, n_out_valid;
    logic        r_rec_done,  n_rec_done;
    logic [1:0]  r_kind,      n_kind;
    logic [1:0]  r_alert,     n_alert;
    logic        r_present,   n_present;
    logic [31:0] r_track,     n_track;
    logic [2:0]  r_err,       n_err;
    logic        r_last,      n_last;
    logic        slot_free;

    assign slot_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_rec_done  = r_rec_done;
        n_kind      = r_kind;
        n_alert     = r_alert;
        n_present   = r_present;
        n_track     = r_track;
        n_err       = r_err;
        n_last      = r_last;
        o_pop       = 1'b0;

        if (slot_free) begin
            n_out_valid = 1'b0;
            if (!i_empty) begin
                n_out_valid = 1'b1;
                if (i_head.rec_valid && !r_rec_done) begin
                    n_kind    = KIND_ALERT;
                    n_alert   = i_head.alert_type;
                    n_present = i_head.track_present;
                    n_track   = i_head.track_number;
                    n_err     = ERR_NONE;
                    n_last    = !i_head.st_valid;
                    if (i_head.st_valid) begin
                        n_rec_done = 1'b1;
                    end else begin
                        o_pop = 1'b1;
                    end
                end else begin
                    n_kind     = (i_head.st_code == ERR_NONE) ? KIND_OK : KIND_ERROR;
                    n_alert    = 2'd0;
                    n_present  = 1'b0;
                    n_track    = 32'd0;
                    n_err      = i_head.st_code;
                    n_last     = 1'b1;
                    n_rec_done = 1'b0;
                    o_pop      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rec_done  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_rec_done  <= n_rec_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_alert   <= n_alert;
        r_present <= n_present;
        r_track   <= n_track;
        r_err     <= n_err;
        r_last    <= n_last;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_kind      = r_kind;
    assign o_out.alert_type    = r_alert;
    assign o_out.track_present = r_present;
    assign o_out.track_number  = r_track;
    assign o_out.error_code    = r_err;
    assign o_out.run_last      = r_last;

    // a record that is not its byte's last result is followed at once by the status
    a_status_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && o_out.out_kind == KIND_ALERT && !o_out.run_last
        |=> o_out.valid && o_out.out_kind != KIND_ALERT && o_out.run_last)
        else $error("status missing after record");

    // error code is nonzero exactly on error status results
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.error_code != ERR_NONE) == (o_out.out_kind == KIND_ERROR)))
        else $error("error code inconsistent with result kind");

endmodule
`default_nettype wire

@@ rtl/asterix_cat245_alert_parser_top.sv @@
// Top level of the ASTERIX category 245 alert data block parser.
//
// Input channel i_in: one byte of a data block per transaction (data_byte),
// last_byte marks the final byte of the received buffer. Output channel
// o_out: one result per transaction - an alert record, a packet ok status
// or a packet error status; run_last flags the last result of one byte.
// Configuration: i_cfg_we/i_cfg_wdata write the expected category (reset 245);
// the user must write it only while the block is idle, the block does not enforce this.
//
// Throughput: one input byte per cycle while the result queue has room. A
// byte that completes a record on the buffer end yields two results, the
// record and then its status; the result queue between parser and output
// stage absorbs such bursts. The first result of a byte is written into
// the queue and then loaded into the output register.
// Reset (synchronous, active low): category register back to 245, parser
// waits for a category byte, queue and output register empty.
// Receiver stall: the output register holds its result, the queue fills and
// i_in.ready drops once it is full; no result is lost.
`default_nettype none
module asterix_cat245_alert_parser_top #(
    parameter int QUEUE_DEPTH = acp_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    acp_in_if.sink          i_in,
    acp_out_if.source       o_out
);
    import acp_pkg::*;

    t_entry q_wr_entry;
    t_entry q_head;
    logic   q_wr;
    logic   q_pop;
    logic   q_empty;
    logic   q_full;

    // front: header and record parsing, one byte per transaction
    acp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_q_wr      (q_wr),
        .o_q_entry   (q_wr_entry)
    );

    // decouples the parser from output stalls
    acp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (q_wr),
        .i_wr_entry (q_wr_entry),
        .i_pop      (q_pop),
        .o_head     (q_head),
        .o_empty    (q_empty),
        .o_full     (q_full)
    );

    // back: record before status, registered output
    acp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
